>>> sv/rkf_pkg.sv
package rkf_pkg;

	localparam int COUNT_W = 3;
	localparam int COLOR_W = 24;
	localparam int CH_W = 8;
	localparam int NUM_CH = 3;
	localparam int TIME_W = 32;
	localparam int KF_W = 56;
	localparam int DUR_LSB = 24;
	localparam int SEG_OUT_W = 2;
	localparam int PROD_W = CH_W + TIME_W;
	localparam int MAX_KEYFRAMES_DEF = 4;

	localparam int ADDR_W = 6;
	localparam int REG_SHIFT = 3;
	localparam int REG_IDX_W = ADDR_W - REG_SHIFT;
	localparam int APB_DATA_W = 64;

	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BASE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KF0 = 3'd2;

	typedef struct packed {
		logic start;
		logic [CH_W-1:0] a;
		logic [CH_W-1:0] b;
	} rkf_fade_req_t;

	typedef struct packed {
		logic done;
		logic [CH_W-1:0] color;
	} rkf_fade_rsp_t;

endpackage

>>> sv/rkf_ram.sv
module rkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> sv/rkf_fade_unit.sv
module rkf_fade_unit import rkf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rkf_fade_req_t     req,
	input  logic [TIME_W-1:0] dt,
	input  logic [TIME_W-1:0] dur,
	output rkf_fade_rsp_t     rsp
);

	localparam int STEP_W = $clog2(CH_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CH_W - 1);

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_ADJ,
		U_DIV
	} ustate_t;

	ustate_t state_q;
	logic [STEP_W-1:0] step_q;
	logic done_q;
	logic [CH_W-1:0] color_q;

	logic neg_q;
	logic [CH_W-1:0] a_q;
	logic [CH_W-1:0] diff_q;
	logic [PROD_W-1:0] acc_q;
	logic [TIME_W-1:0] rem_q;
	logic [CH_W-1:0] quo_q;

	logic [CH_W-1:0] diff_in;
	logic [PROD_W-1:0] acc_next;
	logic [PROD_W-1:0] adj;
	logic [TIME_W:0] trial;
	logic ge;
	logic [TIME_W:0] trial_sub;
	logic [TIME_W-1:0] rem_next;
	logic [CH_W-1:0] quo_next;
	logic [CH_W-1:0] result;
	logic done_next;

	assign diff_in = (req.b >= req.a) ? req.b - req.a : req.a - req.b;
	assign acc_next = {acc_q[PROD_W-2:0], 1'b0}
		+ (diff_q[CH_W-1] ? {{CH_W{1'b0}}, dt} : {PROD_W{1'b0}});
	assign adj = acc_q + (neg_q ? {{CH_W{1'b0}}, dur - TIME_W'(1)} : {PROD_W{1'b0}});
	assign trial = {rem_q, quo_q[CH_W-1]};
	assign ge = trial >= {1'b0, dur};
	assign trial_sub = trial - {1'b0, dur};
	assign rem_next = ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
	assign quo_next = {quo_q[CH_W-2:0], ge};
	assign result = neg_q ? a_q - quo_next : a_q + quo_next;
	assign done_next = (state_q == U_IDLE && req.start && dur == '0)
		|| (state_q == U_DIV && step_q == STEP_LAST);

	assign rsp.done = done_q;
	assign rsp.color = color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
			color_q <= '0;
		end else begin
			done_q <= done_next;
			case (state_q)
				U_IDLE: begin
					step_q <= '0;
					if (req.start) begin
						if (dur == '0) begin
							color_q <= req.b;
						end else begin
							state_q <= U_MUL;
						end
					end
				end
				U_MUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= U_ADJ;
					end
				end
				U_ADJ: begin
					step_q <= '0;
					state_q <= U_DIV;
				end
				U_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						color_q <= result;
						state_q <= U_IDLE;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				a_q <= req.a;
				neg_q <= req.b < req.a;
				diff_q <= diff_in;
				acc_q <= '0;
			end
			U_MUL: begin
				acc_q <= acc_next;
				diff_q <= {diff_q[CH_W-2:0], 1'b0};
			end
			U_ADJ: begin
				rem_q <= adj[PROD_W-1:CH_W];
				quo_q <= adj[CH_W-1:0];
			end
			U_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

>>> sv/rgb_keyframe_fade_engine.sv
// RGB keyframe fade engine.
// Input stream: one request per time stamp, now_ms in s_tdata[31:0].
// Output stream: one color per request; m_tdata carries red [7:0], green [15:8],
// blue [23:16] and the starting keyframe index [25:24].
// Configuration goes through the APB port at byte address 8*i: keyframe count,
// base color, then one 56-bit word per keyframe (duration in bits 55..24,
// color in bits 23..0). Write configuration only while the engine is idle.
// One request is in work at a time. With two or more keyframes a request
// passes from acceptance to the result register through the keyframe reads
// and segment update, then each of three channels in the shared bit-serial
// multiply/divide unit (issue, 8 multiply steps, 1 rounding step, 8 quotient
// steps, handoff), then the result load; a channel with zero duration goes
// from issue straight to handoff. With fewer than two keyframes the held
// color goes straight to the result load. The next request is taken the
// cycle after the result loads.
// The result register lets the next request be accepted while a color waits;
// a stalled receiver holds the engine in its final state until taken.
// Reset clears the count, base color, segment and time reference, marks all
// keyframe words unwritten (they read as zero) and empties the result register.
module rgb_keyframe_fade_engine import rkf_pkg::*; #(
	parameter int MAX_KEYFRAMES = MAX_KEYFRAMES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // now_ms [31:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // red, green, blue, segment_index, zero pad
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int KF_AW = $clog2(MAX_KEYFRAMES);
	localparam int SEG_W = KF_AW;
	localparam logic [COUNT_W-1:0] N_MAX = COUNT_W'(MAX_KEYFRAMES);
	localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_CUR,
		S_CHK,
		S_RD_A,
		S_RD_B,
		S_LD_B,
		S_CH_GO,
		S_CH_WAIT,
		S_FIN
	} state_t;

	state_t state_q;
	logic m_valid_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [SEG_W-1:0] out_seg_q;

	logic [COUNT_W-1:0] count_q;
	logic [COLOR_W-1:0] base_q;
	logic [MAX_KEYFRAMES-1:0] kf_valid_q;
	logic [SEG_W-1:0] seg_q;
	logic [TIME_W-1:0] tref_q;
	logic [COLOR_W-1:0] last_color_q;

	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] dt_q;
	logic [TIME_W-1:0] dur_q;
	logic [COLOR_W-1:0] ca_q;
	logic [COLOR_W-1:0] cb_q;
	logic [COLOR_W-1:0] color_acc_q;
	logic [1:0] ch_q;

	logic [REG_IDX_W-1:0] rd_idx_q;
	logic rd_kf_q;
	logic vb_q;

	logic wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [REG_IDX_W-1:0] kf_off;
	logic kf_hit;
	logic [KF_AW-1:0] kf_addr;
	logic [KF_W-1:0] rdata_a;
	logic [KF_W-1:0] rdata_b;
	logic [KF_W-1:0] kf_b;
	logic [KF_AW-1:0] raddr_b;

	logic [COUNT_W-1:0] n_sat;
	logic [COUNT_W-1:0] seg_inc;
	logic [SEG_W-1:0] seg_next;
	logic [SEG_W-1:0] seg_fix;
	logic [TIME_W-1:0] dt_full;
	logic [TIME_W-1:0] dur_c;
	logic adv;
	logic in_acc;
	logic out_free;

	rkf_fade_req_t req;
	rkf_fade_rsp_t rsp;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:REG_SHIFT];
	assign kf_off = reg_idx - REG_KF0;
	assign kf_hit = (reg_idx >= REG_KF0) && (kf_off < REG_IDX_W'(MAX_KEYFRAMES));
	assign kf_addr = kf_off[KF_AW-1:0];

	assign n_sat = (count_q > N_MAX) ? N_MAX : count_q;
	assign seg_inc = COUNT_W'(seg_q) + COUNT_W'(1);
	assign seg_next = (seg_inc >= n_sat) ? '0 : seg_inc[SEG_W-1:0];
	assign seg_fix = (COUNT_W'(seg_q) >= n_sat) ? '0 : seg_q;

	assign kf_b = vb_q ? rdata_b : '0;
	assign raddr_b = (state_q == S_RD_B) ? seg_next : seg_q;
	assign dt_full = now_q - tref_q;
	assign dur_c = kf_b[KF_W-1:DUR_LSB];
	assign adv = dt_full > dur_c;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata = OUT_DATA_W'({SEG_OUT_W'(out_seg_q), out_color_q[CH_W-1:0],
		out_color_q[2*CH_W-1:CH_W], out_color_q[COLOR_W-1:2*CH_W]});

	assign req.start = (state_q == S_CH_GO);
	assign req.a = ca_q[COLOR_W-1:COLOR_W-CH_W];
	assign req.b = cb_q[COLOR_W-1:COLOR_W-CH_W];

	rkf_ram #(
		.WIDTH(KF_W),
		.DEPTH(MAX_KEYFRAMES)
	) u_kf_ram (
		.clk(clk),
		.we(wr_en && kf_hit),
		.waddr(kf_addr),
		.wdata(pwdata[KF_W-1:0]),
		.raddr_a(kf_addr),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	rkf_fade_unit u_fade (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.dt(dt_q),
		.dur(dur_q),
		.rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			base_q <= '0;
			kf_valid_q <= '0;
			rd_idx_q <= REG_COUNT;
			rd_kf_q <= 1'b0;
			vb_q <= 1'b0;
		end else begin
			rd_idx_q <= reg_idx;
			rd_kf_q <= kf_hit && kf_valid_q[kf_addr];
			vb_q <= kf_valid_q[raddr_b];
			if (wr_en) begin
				case (reg_idx)
					REG_COUNT: count_q <= pwdata[COUNT_W-1:0];
					REG_BASE: base_q <= pwdata[COLOR_W-1:0];
					default: begin
						if (kf_hit) begin
							kf_valid_q[kf_addr] <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		case (rd_idx_q)
			REG_COUNT: prdata = APB_DATA_W'(count_q);
			REG_BASE: prdata = APB_DATA_W'(base_q);
			default: prdata = rd_kf_q ? APB_DATA_W'(rdata_a) : '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
			tref_q <= '0;
			last_color_q <= '0;
		end else begin
			if (in_acc && n_sat >= COUNT_W'(2)) begin
				seg_q <= seg_fix;
			end else if (state_q == S_CHK && adv) begin
				seg_q <= seg_next;
				tref_q <= now_q;
			end
			if (wr_en && reg_idx == REG_BASE) begin
				last_color_q <= pwdata[COLOR_W-1:0];
			end else if (state_q == S_FIN && out_free) begin
				last_color_q <= color_acc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				now_q <= s_tdata[TIME_W-1:0];
				color_acc_q <= last_color_q;
			end
			S_CHK: begin
				dt_q <= adv ? TIME_W'(1) : dt_full;
			end
			S_RD_B: begin
				ca_q <= kf_b[COLOR_W-1:0];
				dur_q <= dur_c;
			end
			S_LD_B: begin
				cb_q <= kf_b[COLOR_W-1:0];
			end
			S_CH_WAIT: begin
				if (rsp.done) begin
					color_acc_q <= {color_acc_q[COLOR_W-CH_W-1:0], rsp.color};
					ca_q <= {ca_q[COLOR_W-CH_W-1:0], {CH_W{1'b0}}};
					cb_q <= {cb_q[COLOR_W-CH_W-1:0], {CH_W{1'b0}}};
				end
			end
			default: begin
				now_q <= now_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= '0;
			m_valid_q <= 1'b0;
			out_color_q <= '0;
			out_seg_q <= '0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= (n_sat >= COUNT_W'(2)) ? S_RD_CUR : S_FIN;
					end
				end
				S_RD_CUR: state_q <= S_CHK;
				S_CHK: state_q <= S_RD_A;
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: state_q <= S_LD_B;
				S_LD_B: begin
					ch_q <= '0;
					state_q <= S_CH_GO;
				end
				S_CH_GO: state_q <= S_CH_WAIT;
				S_CH_WAIT: begin
					if (rsp.done) begin
						ch_q <= ch_q + 2'd1;
						state_q <= (ch_q == CH_LAST) ? S_FIN : S_CH_GO;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_color_q <= color_acc_q;
						out_seg_q <= seg_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != S_IDLE)
		else $error("accepted request left the engine idle");

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_CH_WAIT)
		else $error("channel result arrived with no channel pending");

	a_tref_update: assert property (@(posedge clk) disable iff (!arst_n)
		tref_q != $past(tref_q) |-> $past(state_q == S_CHK))
		else $error("time reference moved outside the segment check");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_FIN))
		else $error("result register loaded outside the final state");

endmodule
